[hw/rtl/power_autorange_text_formatter_macros.svh]
// assertion macros used by the formatter top level
`ifndef POWER_AUTORANGE_TEXT_FORMATTER_MACROS_SVH
`define POWER_AUTORANGE_TEXT_FORMATTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition must hold on every clock outside reset
`define PARF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("formatter check failed");
// consequent must hold in the same cycle as the antecedent
`define PARF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("formatter check failed");
`else
`define PARF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PARF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/parf_pkg.sv]
// shared types, constants and decode tables of the power formatter
`timescale 1ns / 1ps

package parf_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned MANT_W = 10;
    localparam int unsigned DIV_W  = 24;
    localparam int unsigned PROD_W = 35;
    localparam int unsigned LINE_W = 64;
    localparam int unsigned NUM_LIMITS = 7;

    typedef logic [7:0] t_char;

    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_EQ    = 8'h3D;
    localparam t_char CH_CAP_P = 8'h50;
    localparam t_char CH_CAP_W = 8'h57;
    localparam t_char CH_LOW_P = 8'h70;
    localparam t_char CH_LOW_N = 8'h6E;
    localparam t_char CH_LOW_U = 8'h75;
    localparam t_char CH_LOW_M = 8'h6D;

    typedef enum logic [1:0] {
        UNIT_PW = 2'd0,
        UNIT_NW = 2'd1,
        UNIT_UW = 2'd2,
        UNIT_MW = 2'd3
    } t_unit;

    typedef enum logic [1:0] {
        PT_NONE      = 2'd0,
        PT_AFTER_TWO = 2'd1,
        PT_AFTER_ONE = 2'd2
    } t_point;

    // beat leaving the decade search
    typedef struct packed {
        logic               valid;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   idx;
    } t_range_beat;

    // beat leaving the scaler
    typedef struct packed {
        logic               valid;
        logic [MANT_W-1:0]  mant;
        logic [IDX_W-1:0]   idx;
    } t_mant_beat;

    // lower bound of decade index idx+1, that is 10^(idx+3)
    function automatic logic [VAL_W-1:0] decade_limit(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] lim;
        unique case (idx)
            3'd0:    lim = 32'd1000;
            3'd1:    lim = 32'd10000;
            3'd2:    lim = 32'd100000;
            3'd3:    lim = 32'd1000000;
            3'd4:    lim = 32'd10000000;
            3'd5:    lim = 32'd100000000;
            3'd6:    lim = 32'd1000000000;
            default: lim = 32'hFFFF_FFFF;
        endcase
        return lim;
    endfunction

    // scale divisor 10^idx
    function automatic logic [DIV_W-1:0] divisor(input logic [IDX_W-1:0] idx);
        logic [DIV_W-1:0] d;
        unique case (idx)
            3'd0:    d = 24'd1;
            3'd1:    d = 24'd10;
            3'd2:    d = 24'd100;
            3'd3:    d = 24'd1000;
            3'd4:    d = 24'd10000;
            3'd5:    d = 24'd100000;
            3'd6:    d = 24'd1000000;
            default: d = 24'd10000000;
        endcase
        return d;
    endfunction

    // floor(2^32 / 10^idx); unit divisor is bypassed by the scaler
    function automatic logic [VAL_W-1:0] recip(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] m;
        unique case (idx)
            3'd1:    m = 32'd429496729;
            3'd2:    m = 32'd42949672;
            3'd3:    m = 32'd4294967;
            3'd4:    m = 32'd429496;
            3'd5:    m = 32'd42949;
            3'd6:    m = 32'd4294;
            3'd7:    m = 32'd429;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    // point placement repeats every three decades
    function automatic t_point point_of(input logic [IDX_W-1:0] idx);
        t_point p;
        unique case (idx)
            3'd1, 3'd4, 3'd7: p = PT_AFTER_ONE;
            3'd2, 3'd5:       p = PT_AFTER_TWO;
            default:          p = PT_NONE;
        endcase
        return p;
    endfunction

    function automatic t_unit unit_of(input logic [IDX_W-1:0] idx);
        t_unit u;
        unique case (idx)
            3'd0:             u = UNIT_PW;
            3'd1, 3'd2, 3'd3: u = UNIT_NW;
            3'd4, 3'd5, 3'd6: u = UNIT_UW;
            default:          u = UNIT_MW;
        endcase
        return u;
    endfunction

    function automatic t_char unit_letter(input t_unit u);
        t_char c;
        unique case (u)
            UNIT_PW: c = CH_LOW_P;
            UNIT_NW: c = CH_LOW_N;
            UNIT_UW: c = CH_LOW_U;
            default: c = CH_LOW_M;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/power_autorange_text_formatter.sv]
// top level of the power autorange text formatter
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  command   | start, busy        | i_power_pw
//  result    | o_valid (strobe)   | o_line_chars_left/right, o_mantissa,
//            |                    | o_point_position, o_unit_code
//
// one beat per cycle, from command through the stages below to result strobe
// stages: decade compare, reciprocal multiply, bound multiply, correction,
// digit split, line assembly; the two multipliers set the stage depth
// busy stays low: results are strobed out and never held back
// synchronous active-low reset clears the valid bits of every stage
`timescale 1ns / 1ps
`include "power_autorange_text_formatter_macros.svh"

module power_autorange_text_formatter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [parf_pkg::VAL_W-1:0]          i_power_pw,
    output logic                                o_valid,
    output logic [parf_pkg::LINE_W-1:0]         o_line_chars_left,
    output logic [parf_pkg::LINE_W-1:0]         o_line_chars_right,
    output logic [parf_pkg::MANT_W-1:0]         o_mantissa,
    output logic [1:0]                          o_point_position,
    output logic [1:0]                          o_unit_code
);

    parf_pkg::t_range_beat  range_beat;
    parf_pkg::t_mant_beat   mant_beat;
    parf_pkg::t_point       point;
    parf_pkg::t_unit        unit;
    logic                   has_point;
    logic                   is_pw;
    logic [23:0]            line_head;

    // the pipeline never stalls
    assign busy = 1'b0;

    parf_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_value (i_power_pw),
        .o_beat  (range_beat)
    );

    parf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (range_beat),
        .o_beat  (mant_beat)
    );

    parf_text u_text (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (mant_beat),
        .o_valid (o_valid),
        .o_left  (o_line_chars_left),
        .o_right (o_line_chars_right),
        .o_mant  (o_mantissa),
        .o_point (point),
        .o_unit  (unit)
    );

    assign o_point_position = point;
    assign o_unit_code      = unit;

    // checks on the result beat
    assign has_point = o_valid && (point != parf_pkg::PT_NONE);
    assign is_pw     = o_valid && (unit == parf_pkg::UNIT_PW);
    assign line_head = o_line_chars_left[63:40];
    `PARF_ASSERT_IMPLIES(a_mant_range, i_clk, i_rst_n, o_valid, o_mantissa <= 10'd999)
    `PARF_ASSERT_IMPLIES(a_point_full, i_clk, i_rst_n, has_point, o_mantissa >= 10'd100)
    `PARF_ASSERT_IMPLIES(a_pw_no_point, i_clk, i_rst_n, is_pw, point == parf_pkg::PT_NONE)
    `PARF_ASSERT_IMPLIES(a_line_head, i_clk, i_rst_n, o_valid, line_head == 24'h20503D)

endmodule

[hw/rtl/parf_range.sv]
// decade search stage: counts the decade limits the value reaches
`timescale 1ns / 1ps

module parf_range (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [parf_pkg::VAL_W-1:0]          i_value,
    output parf_pkg::t_range_beat               o_beat
);

    logic                           r_valid;
    logic [parf_pkg::VAL_W-1:0]     r_value;
    logic [parf_pkg::IDX_W-1:0]     r_idx;
    logic [parf_pkg::IDX_W-1:0]     n_idx;

    // independent compares against 10^3 .. 10^9, summed
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < parf_pkg::NUM_LIMITS; i++) begin
            if (i_value >= parf_pkg::decade_limit(parf_pkg::IDX_W'(i))) begin
                n_idx = n_idx + parf_pkg::IDX_W'(1);
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_value <= i_value;
        r_idx   <= n_idx;
    end

    assign o_beat = '{valid: r_valid, value: r_value, idx: r_idx};

endmodule

[hw/rtl/parf_scale.sv]
// scaler: divides by 10^idx via reciprocal multiply and one-step correction
`timescale 1ns / 1ps

module parf_scale (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  parf_pkg::t_range_beat   i_beat,
    output parf_pkg::t_mant_beat    o_beat
);

    localparam int unsigned QW = parf_pkg::MANT_W + 1;

    // stage a: quotient estimate
    logic                           r_a_valid;
    logic [parf_pkg::VAL_W-1:0]     r_a_value;
    logic [parf_pkg::IDX_W-1:0]     r_a_idx;
    logic [parf_pkg::MANT_W-1:0]    r_a_qest;
    logic [2*parf_pkg::VAL_W-1:0]   n_a_prod;
    logic [parf_pkg::MANT_W-1:0]    n_a_qest;

    // stage b: bound for the next quotient
    logic                           r_b_valid;
    logic [parf_pkg::VAL_W-1:0]     r_b_value;
    logic [parf_pkg::IDX_W-1:0]     r_b_idx;
    logic [parf_pkg::MANT_W-1:0]    r_b_qest;
    logic [parf_pkg::PROD_W-1:0]    r_b_bound;
    logic [QW-1:0]                  n_b_qinc;
    logic [parf_pkg::PROD_W-1:0]    n_b_bound;

    // stage c: corrected mantissa
    logic                           r_c_valid;
    logic [parf_pkg::IDX_W-1:0]     r_c_idx;
    logic [parf_pkg::MANT_W-1:0]    r_c_mant;
    logic [parf_pkg::MANT_W-1:0]    n_c_mant;

    // estimate is exact or one low; unit divisor passes the value through
    always_comb begin
        n_a_prod = (2*parf_pkg::VAL_W)'(i_beat.value)
                 * (2*parf_pkg::VAL_W)'(parf_pkg::recip(i_beat.idx));
        if (i_beat.idx == '0) begin
            n_a_qest = i_beat.value[parf_pkg::MANT_W-1:0];
        end else begin
            n_a_qest = n_a_prod[parf_pkg::VAL_W +: parf_pkg::MANT_W];
        end
    end

    // (q+1) * divisor, checked against the value next stage
    always_comb begin
        n_b_qinc  = QW'(r_a_qest) + QW'(1);
        n_b_bound = parf_pkg::PROD_W'(n_b_qinc)
                  * parf_pkg::PROD_W'(parf_pkg::divisor(r_a_idx));
    end

    always_comb begin
        if (parf_pkg::PROD_W'(r_b_value) >= r_b_bound) begin
            n_c_mant = r_b_qest + parf_pkg::MANT_W'(1);
        end else begin
            n_c_mant = r_b_qest;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_beat.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_a_value <= i_beat.value;
        r_a_idx   <= i_beat.idx;
        r_a_qest  <= n_a_qest;
        r_b_value <= r_a_value;
        r_b_idx   <= r_a_idx;
        r_b_qest  <= r_a_qest;
        r_b_bound <= n_b_bound;
        r_c_idx   <= r_b_idx;
        r_c_mant  <= n_c_mant;
    end

    assign o_beat = '{valid: r_c_valid, mant: r_c_mant, idx: r_c_idx};

endmodule

[hw/rtl/parf_text.sv]
// text stage: splits the mantissa into digits and builds the display line
`timescale 1ns / 1ps

module parf_text (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  parf_pkg::t_mant_beat            i_beat,
    output logic                            o_valid,
    output logic [parf_pkg::LINE_W-1:0]     o_left,
    output logic [parf_pkg::LINE_W-1:0]     o_right,
    output logic [parf_pkg::MANT_W-1:0]     o_mant,
    output parf_pkg::t_point                o_point,
    output parf_pkg::t_unit                 o_unit
);

    // digit split
    logic [15:0]                    n_h_prod;
    logic [3:0]                     n_hund;
    logic [6:0]                     n_rem;
    logic [14:0]                    n_t_prod;
    logic [3:0]                     n_tens;
    logic [3:0]                     n_unit_dig;

    logic                           r_d_valid;
    logic [parf_pkg::MANT_W-1:0]    r_d_mant;
    logic [parf_pkg::IDX_W-1:0]     r_d_idx;
    logic [3:0]                     r_d_hund;
    logic [3:0]                     r_d_tens;
    logic [3:0]                     r_d_units;

    // line assembly
    parf_pkg::t_char                n_ch [16];
    parf_pkg::t_char                n_c0;
    parf_pkg::t_char                n_c1;
    parf_pkg::t_char                n_c2;
    parf_pkg::t_point               n_point;
    parf_pkg::t_unit                n_unit;
    logic [parf_pkg::LINE_W-1:0]    n_left;
    logic [parf_pkg::LINE_W-1:0]    n_right;

    logic                           r_valid;
    logic [parf_pkg::LINE_W-1:0]    r_left;
    logic [parf_pkg::LINE_W-1:0]    r_right;
    logic [parf_pkg::MANT_W-1:0]    r_mant;
    parf_pkg::t_point               r_point;
    parf_pkg::t_unit                r_unit;

    // hundreds = m*41 >> 12, tens = r*205 >> 11, exact over these ranges
    always_comb begin
        n_h_prod   = 16'(i_beat.mant) * 16'd41;
        n_hund     = n_h_prod[15:12];
        n_rem      = 7'(i_beat.mant - 10'(n_hund) * 10'd100);
        n_t_prod   = 15'(n_rem) * 15'd205;
        n_tens     = n_t_prod[14:11];
        n_unit_dig = 4'(n_rem - 7'(n_tens) * 7'd10);
    end

    // characters of the number, leading zeros shown as spaces
    always_comb begin
        n_point = parf_pkg::point_of(r_d_idx);
        n_unit  = parf_pkg::unit_of(r_d_idx);
        n_c0 = (r_d_mant >= 10'd100) ? (parf_pkg::CH_ZERO + 8'(r_d_hund))
                                     : parf_pkg::CH_SPACE;
        n_c1 = (r_d_mant >= 10'd10)  ? (parf_pkg::CH_ZERO + 8'(r_d_tens))
                                     : parf_pkg::CH_SPACE;
        n_c2 = parf_pkg::CH_ZERO + 8'(r_d_units);

        for (int i = 0; i < 16; i++) begin
            n_ch[i] = parf_pkg::CH_SPACE;
        end
        n_ch[1] = parf_pkg::CH_CAP_P;
        n_ch[2] = parf_pkg::CH_EQ;
        n_ch[3] = n_c0;
        case (n_point)
            parf_pkg::PT_AFTER_ONE: begin
                n_ch[4] = parf_pkg::CH_DOT;
                n_ch[5] = n_c1;
                n_ch[6] = n_c2;
                n_ch[8] = parf_pkg::unit_letter(n_unit);
                n_ch[9] = parf_pkg::CH_CAP_W;
            end
            parf_pkg::PT_AFTER_TWO: begin
                n_ch[4] = n_c1;
                n_ch[5] = parf_pkg::CH_DOT;
                n_ch[6] = n_c2;
                n_ch[8] = parf_pkg::unit_letter(n_unit);
                n_ch[9] = parf_pkg::CH_CAP_W;
            end
            default: begin
                n_ch[4] = n_c1;
                n_ch[5] = n_c2;
                n_ch[7] = parf_pkg::unit_letter(n_unit);
                n_ch[8] = parf_pkg::CH_CAP_W;
            end
        endcase

        // character 0 goes to the top byte
        for (int i = 0; i < 8; i++) begin
            n_left[(7-i)*8 +: 8]  = n_ch[i];
            n_right[(7-i)*8 +: 8] = n_ch[i+8];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_d_valid <= i_beat.valid;
            r_valid   <= r_d_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_d_mant  <= i_beat.mant;
        r_d_idx   <= i_beat.idx;
        r_d_hund  <= n_hund;
        r_d_tens  <= n_tens;
        r_d_units <= n_unit_dig;
        r_left    <= n_left;
        r_right   <= n_right;
        r_mant    <= r_d_mant;
        r_point   <= n_point;
        r_unit    <= n_unit;
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_mant  = r_mant;
    assign o_point = r_point;
    assign o_unit  = r_unit;

endmodule

[bench/power_autorange_text_formatter_test.sv]
// self-checking testbench of the power autorange text formatter
`timescale 1ns / 1ps

module power_autorange_text_formatter_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_PER_PHASE = 113;

    // expected fields of one display line
    typedef struct {
        logic [parf_pkg::LINE_W-1:0] left;
        logic [parf_pkg::LINE_W-1:0] right;
        logic [parf_pkg::MANT_W-1:0] mant;
        parf_pkg::t_point            pt;
        parf_pkg::t_unit             unit;
    } t_line_fields;

    // one queued measurement with the sender idle rate of its phase
    typedef struct {
        logic [parf_pkg::VAL_W-1:0] power;
        int unsigned                idle_pct;
    } t_power_item;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [parf_pkg::VAL_W-1:0]  i_power_pw = '0;
    logic                        o_valid;
    logic [parf_pkg::LINE_W-1:0] o_line_chars_left;
    logic [parf_pkg::LINE_W-1:0] o_line_chars_right;
    logic [parf_pkg::MANT_W-1:0] o_mantissa;
    logic [1:0]                  o_point_position;
    logic [1:0]                  o_unit_code;

    t_power_item  power_backlog[$];
    t_line_fields pending_lines[$];
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;

    power_autorange_text_formatter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_power_pw         (i_power_pw),
        .o_valid            (o_valid),
        .o_line_chars_left  (o_line_chars_left),
        .o_line_chars_right (o_line_chars_right),
        .o_mantissa         (o_mantissa),
        .o_point_position   (o_point_position),
        .o_unit_code        (o_unit_code)
    );

    // decade search, truncation to three digits and line text
    function automatic t_line_fields format_power(input logic [parf_pkg::VAL_W-1:0] pw);
        logic [63:0]      v;
        logic [63:0]      decade;
        logic [63:0]      q;
        int unsigned      k;
        int unsigned      m;
        int unsigned      pos;
        parf_pkg::t_char  digs[3];
        parf_pkg::t_char  txt[16];
        parf_pkg::t_char  letter;
        t_line_fields     r;
        v = {32'd0, pw};
        k = 3;
        decade = 64'd1000;
        while (k < 10 && v >= decade) begin
            k++;
            decade = decade * 10;
        end
        q = v / (decade / 1000);
        m = (q > 64'd999) ? 999 : int'(q);
        r.mant = m[parf_pkg::MANT_W-1:0];
        case (k % 3)
            0: r.pt = parf_pkg::PT_NONE;
            1: r.pt = parf_pkg::PT_AFTER_ONE;
            default: r.pt = parf_pkg::PT_AFTER_TWO;
        endcase
        if (k == 3) begin
            r.unit = parf_pkg::UNIT_PW;
            letter = parf_pkg::CH_LOW_P;
        end else if (k <= 6) begin
            r.unit = parf_pkg::UNIT_NW;
            letter = parf_pkg::CH_LOW_N;
        end else if (k <= 9) begin
            r.unit = parf_pkg::UNIT_UW;
            letter = parf_pkg::CH_LOW_U;
        end else begin
            r.unit = parf_pkg::UNIT_MW;
            letter = parf_pkg::CH_LOW_M;
        end
        // right-justified digits with leading blanks
        digs[0] = (m >= 100) ? parf_pkg::CH_ZERO + 8'(m / 100) : parf_pkg::CH_SPACE;
        digs[1] = (m >= 10) ? parf_pkg::CH_ZERO + 8'((m / 10) % 10) : parf_pkg::CH_SPACE;
        digs[2] = parf_pkg::CH_ZERO + 8'(m % 10);
        foreach (txt[i]) txt[i] = parf_pkg::CH_SPACE;
        txt[1] = parf_pkg::CH_CAP_P;
        txt[2] = parf_pkg::CH_EQ;
        pos = 3;
        for (int d = 0; d < 3; d++) begin
            txt[pos] = digs[d];
            pos++;
            if ((r.pt == parf_pkg::PT_AFTER_ONE && d == 0) ||
                (r.pt == parf_pkg::PT_AFTER_TWO && d == 1)) begin
                txt[pos] = parf_pkg::CH_DOT;
                pos++;
            end
        end
        pos++;
        txt[pos] = letter;
        txt[pos+1] = parf_pkg::CH_CAP_W;
        r.left = '0;
        r.right = '0;
        for (int i = 0; i < 8; i++) begin
            r.left = {r.left[parf_pkg::LINE_W-9:0], txt[i]};
            r.right = {r.right[parf_pkg::LINE_W-9:0], txt[i+8]};
        end
        return r;
    endfunction

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // reset, then wait out the stimulus
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (power_backlog.size() != 0 || start || pending_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // stimulus: directed corners, then random phases
    initial begin : fill_backlog
        logic [parf_pkg::VAL_W-1:0] corners[25];
        int unsigned                phase_idle[4];
        logic [63:0]                lo;
        logic [63:0]                hi;
        logic [63:0]                p;
        int unsigned                k;
        int unsigned                sel;
        t_power_item                it;
        corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                    32'd1001, 32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999,
                    32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999,
                    32'd100000000, 32'd999999999, 32'd1000000000, 32'd1000000001,
                    32'd123456789, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        phase_idle = '{0, 73, 0, 22};
        foreach (corners[i]) begin
            it.power = corners[i];
            it.idle_pct = 0;
            power_backlog.push_back(it);
        end
        foreach (phase_idle[ph]) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                sel = $urandom_range(9, 0);
                if (sel <= 5) begin
                    // value within a random decade
                    k = $urandom_range(10, 3);
                    p = 64'd1;
                    for (int j = 0; j < k; j++) p = p * 10;
                    lo = (k == 3) ? 64'd0 : p / 10;
                    hi = (p - 1 > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p - 1;
                    it.power = $urandom_range(hi[31:0], lo[31:0]);
                end else if (sel <= 7) begin
                    // just around a decade boundary
                    k = $urandom_range(9, 3);
                    p = 64'd1;
                    for (int j = 0; j < k; j++) p = p * 10;
                    p = p + $urandom_range(2, 0) - 1;
                    it.power = p[31:0];
                end else begin
                    it.power = $urandom;
                end
                it.idle_pct = phase_idle[ph];
                power_backlog.push_back(it);
            end
        end
    end

    // driver: one command beat per accepted start
    always @(posedge i_clk) begin : cmd_driver
        t_power_item next_item;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                pending_lines.push_back(format_power(i_power_pw));
            if (!start || !busy) begin
                if (power_backlog.size() != 0 &&
                    $urandom_range(99, 0) >= power_backlog[0].idle_pct) begin
                    next_item = power_backlog.pop_front();
                    start <= 1'b1;
                    i_power_pw <= next_item.power;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expected line
    always @(posedge i_clk) begin : result_check
        t_line_fields want;
        if (i_rst_n && o_valid) begin
            if (pending_lines.size() == 0) begin
                $display("%0t: result beat with nothing expected, left %h right %h",
                         $time, o_line_chars_left, o_line_chars_right);
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                if (o_line_chars_left !== want.left) begin
                    $display("%0t: line left expected %h actual %h",
                             $time, want.left, o_line_chars_left);
                    mismatches++;
                end
                if (o_line_chars_right !== want.right) begin
                    $display("%0t: line right expected %h actual %h",
                             $time, want.right, o_line_chars_right);
                    mismatches++;
                end
                if (o_mantissa !== want.mant) begin
                    $display("%0t: mantissa expected %0d actual %0d",
                             $time, want.mant, o_mantissa);
                    mismatches++;
                end
                if (o_point_position !== want.pt) begin
                    $display("%0t: point position expected %0d actual %0d",
                             $time, want.pt, o_point_position);
                    mismatches++;
                end
                if (o_unit_code !== want.unit) begin
                    $display("%0t: unit code expected %0d actual %0d",
                             $time, want.unit, o_unit_code);
                    mismatches++;
                end
            end
        end
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/parf_pkg.sv
hw/rtl/parf_range.sv
hw/rtl/parf_scale.sv
hw/rtl/parf_text.sv
hw/rtl/power_autorange_text_formatter.sv
bench/power_autorange_text_formatter_test.sv
